/* rtl/assert_macros.svh */
// Assertion helpers. All checks are clocked on clk and held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DTGF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define DTGF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DTGF_ASSERT_SAME(lbl, ante, cons, msg)

`define DTGF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/dtgf_pkg.sv */
package dtgf_pkg;

	localparam int BYTES_PER_ROW = 64;
	localparam int ROW_COUNT     = 64;
	localparam int STORE_DEPTH   = ROW_COUNT * BYTES_PER_ROW;

	localparam int PIX_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int COL_W  = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
	localparam int ROW_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

	// payload field widths
	localparam int CMD_W  = 2;
	localparam int X_W    = 8;
	localparam int Y_W    = 6;
	localparam int KIND_W = 2;
	localparam int CCOL_W = 6;
	localparam int CROW_W = 6;
	localparam int BYTE_W = 8;

	localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

	// pixel k of a store byte lives in bits 2k+1..2k
	localparam logic [BYTE_W-1:0] FIELD_MASK [4] = '{8'h03, 8'h0C, 8'h30, 8'hC0};

	typedef struct packed {
		logic                     pix_rd;
		logic                     pix_wr;
		logic [PIX_AW-1:0]        pix_addr;
		logic [BYTE_W-1:0]        pix_wdata;
		logic                     dty_rd;
		logic                     dty_wr;
		logic [ROW_W-1:0]         dty_addr;
		logic [BYTES_PER_ROW-1:0] dty_wdata;
	} store_req_t;

	function automatic logic [PIX_AW-1:0] store_addr(input logic [Y_W-1:0] row,
		input logic [COL_W-1:0] col);
		return PIX_AW'(int'(row) * BYTES_PER_ROW + int'(col));
	endfunction

	// two 2-bit levels, each doubled to a nibble, first one in the high nibble
	function automatic logic [BYTE_W-1:0] expand_pair(input logic [1:0] a,
		input logic [1:0] b);
		return {a, a, b, b};
	endfunction

endpackage

/* rtl/dtgf_cmd_if.sv */
interface dtgf_cmd_if import dtgf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [X_W-1:0]   x;
	logic [Y_W-1:0]   y;
	logic             value;

	modport source (output valid, output cmd, output x, output y, output value,
		input ready);
	modport sink (input valid, input cmd, input x, input y, input value,
		output ready);
endinterface

/* rtl/dtgf_res_if.sv */
interface dtgf_res_if import dtgf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CCOL_W-1:0] cell_column;
	logic [CROW_W-1:0] cell_row;
	logic [BYTE_W-1:0] pixels_left;
	logic [BYTE_W-1:0] pixels_right;
	logic              changed;
	logic              last;

	modport source (output valid, output kind, output cell_column, output cell_row,
		output pixels_left, output pixels_right, output changed, output last,
		input ready);
	modport sink (input valid, input kind, input cell_column, input cell_row,
		input pixels_left, input pixels_right, input changed, input last,
		output ready);
endinterface

/* rtl/dtgf_store.sv */
// Pixel store and per-row dirty words, one port each, registered reads.
module dtgf_store import dtgf_pkg::*; (
	input  logic                     clk,
	input  store_req_t               req,
	output logic [BYTE_W-1:0]        pix_rdata,
	output logic [BYTES_PER_ROW-1:0] dty_rdata
);

	logic [BYTE_W-1:0]        pix_mem [STORE_DEPTH];
	logic [BYTES_PER_ROW-1:0] dty_mem [ROW_COUNT];
	logic [BYTE_W-1:0]        pix_rdata_q;
	logic [BYTES_PER_ROW-1:0] dty_rdata_q;

	always_ff @(posedge clk) begin
		if (req.pix_wr) begin
			pix_mem[req.pix_addr] <= req.pix_wdata;
		end
		if (req.pix_rd) begin
			pix_rdata_q <= pix_mem[req.pix_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.dty_wr) begin
			dty_mem[req.dty_addr] <= req.dty_wdata;
		end
		if (req.dty_rd) begin
			dty_rdata_q <= dty_mem[req.dty_addr];
		end
	end

	assign pix_rdata = pix_rdata_q;
	assign dty_rdata = dty_rdata_q;

endmodule

/* rtl/dirty_tracked_gray_framebuffer.sv */
// Gray framebuffer of ROW_COUNT rows by BYTES_PER_ROW store bytes, four 2-bit pixels a
// byte, with one dirty bit per byte. The command channel takes one command at a time
// and is not ready until that command is finished; every result sits in an output
// register, so the command channel reopens while the last result still waits. A set
// pixel does one read and one write of the single store port. A flush reads the dirty
// word, walks the columns up to the last dirty one and emits each dirty byte; the
// column walk is set by the one store port and one column step per cycle, pausing at
// each dirty byte until its result is taken into the output register. Clear walks the
// whole store, one byte a cycle, and then acknowledges. After reset the same walk
// clears the store and dirty words, during which no command is taken.
`include "assert_macros.svh"

module dirty_tracked_gray_framebuffer import dtgf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	dtgf_cmd_if.sink  cmd_ch,
	dtgf_res_if.source res_ch
);

	typedef enum logic [6:0] {
		S_CLR     = 7'b000_0001, // sweep of the store
		S_IDLE    = 7'b000_0010,
		S_SP_WR   = 7'b000_0100, // set pixel: compare and write back
		S_FL_LOAD = 7'b000_1000, // flush: dirty word arrives
		S_FL_SCAN = 7'b001_0000, // flush: one column per cycle
		S_FL_EMIT = 7'b010_0000, // flush: emit a dirty byte
		S_ACK     = 7'b100_0000  // single ack or empty-row result
	} state_t;

	state_t state_q, state_d;

	// sweep control
	logic [PIX_AW-1:0] cnt_q;
	logic              clr_dirty_q;   // reset sweep also clears dirty words
	logic              clr_ack_q;     // clear command sweep ends with an ack

	// command latch
	logic [X_W-1:0]    x_q;
	logic [Y_W-1:0]    y_q;
	logic              value_q;
	logic [KIND_W-1:0] ack_kind_q;

	// flush walk
	logic [COL_W-1:0]         col_q;
	logic [BYTES_PER_ROW-1:0] scan_q;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [CCOL_W-1:0] out_col_q;
	logic [CROW_W-1:0] out_row_q;
	logic [BYTE_W-1:0] out_left_q;
	logic [BYTE_W-1:0] out_right_q;
	logic              out_changed_q;
	logic              out_last_q;

	store_req_t               store_req;
	logic [BYTE_W-1:0]        pix_rdata;
	logic [BYTES_PER_ROW-1:0] dty_rdata;

	dtgf_store u_store (
		.clk       (clk),
		.req       (store_req),
		.pix_rdata (pix_rdata),
		.dty_rdata (dty_rdata)
	);

	logic              slot_free;
	logic              accept;
	logic              out_load;
	logic [KIND_W-1:0] o_kind;
	logic [CCOL_W-1:0] o_col;
	logic [CROW_W-1:0] o_row;
	logic [BYTE_W-1:0] o_left;
	logic [BYTE_W-1:0] o_right;
	logic              o_changed;
	logic              o_last;

	logic [5:0]        in_col;
	logic              in_row_ok;
	logic              in_set_ok;

	logic [5:0]               sp_col;
	logic [BYTE_W-1:0]        sp_mask;
	logic [BYTE_W-1:0]        sp_want;
	logic                     sp_changed;
	logic [BYTES_PER_ROW-1:0] col_bit;
	logic [BYTES_PER_ROW-1:0] scan_rest;
	logic                     fl_last;

	assign slot_free = !out_valid_q || res_ch.ready;
	assign cmd_ch.ready = (state_q == S_IDLE);
	assign accept = cmd_ch.valid && cmd_ch.ready;

	// range checks on the incoming command
	assign in_col    = cmd_ch.x[7:2];
	assign in_row_ok = 9'(cmd_ch.y) < 9'(ROW_COUNT);
	assign in_set_ok = in_row_ok && (9'(in_col) < 9'(BYTES_PER_ROW));

	// set pixel: field compare against the byte just read
	assign sp_col     = x_q[7:2];
	assign sp_mask    = FIELD_MASK[x_q[1:0]];
	assign sp_want    = value_q ? sp_mask : '0;
	assign sp_changed = (pix_rdata & sp_mask) != sp_want;

	// flush: is the byte being emitted the last dirty one of the row?
	assign col_bit   = BYTES_PER_ROW'(1) << col_q;
	assign scan_rest = scan_q & ~col_bit;
	assign fl_last   = (scan_rest == '0);

	always_comb begin
		state_d   = state_q;
		store_req = '0;
		out_load  = 1'b0;
		o_kind    = KIND_ACK;
		o_col     = '0;
		o_row     = '0;
		o_left    = '0;
		o_right   = '0;
		o_changed = 1'b0;
		o_last    = 1'b1;
		unique case (state_q)
			S_CLR: begin
				store_req.pix_wr   = 1'b1;
				store_req.pix_addr = cnt_q;
				if (clr_dirty_q && (cnt_q < PIX_AW'(ROW_COUNT))) begin
					store_req.dty_wr   = 1'b1;
					store_req.dty_addr = ROW_W'(cnt_q);
				end
				if (cnt_q == PIX_AW'(STORE_DEPTH - 1)) begin
					state_d = clr_ack_q ? S_ACK : S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd_ch.valid) begin
					case (cmd_ch.cmd)
						CMD_SET: begin
							if (in_set_ok) begin
								store_req.pix_rd   = 1'b1;
								store_req.pix_addr = store_addr(cmd_ch.y, COL_W'(in_col));
								store_req.dty_rd   = 1'b1;
								store_req.dty_addr = ROW_W'(cmd_ch.y);
								state_d = S_SP_WR;
							end else begin
								state_d = S_ACK;
							end
						end
						CMD_FLUSH: begin
							if (in_row_ok) begin
								store_req.dty_rd   = 1'b1;
								store_req.dty_addr = ROW_W'(cmd_ch.y);
								state_d = S_FL_LOAD;
							end else begin
								state_d = S_ACK;
							end
						end
						CMD_CLEAR: state_d = S_CLR;
						default:   state_d = S_ACK;
					endcase
				end
			end
			S_SP_WR: begin
				if (slot_free) begin
					out_load  = 1'b1;
					o_changed = sp_changed;
					if (sp_changed) begin
						store_req.pix_wr    = 1'b1;
						store_req.pix_addr  = store_addr(y_q, COL_W'(sp_col));
						store_req.pix_wdata = (pix_rdata & ~sp_mask) | sp_want;
						store_req.dty_wr    = 1'b1;
						store_req.dty_addr  = ROW_W'(y_q);
						store_req.dty_wdata = dty_rdata | (BYTES_PER_ROW'(1) << COL_W'(sp_col));
					end
					state_d = S_IDLE;
				end
			end
			S_FL_LOAD: begin
				state_d = (dty_rdata == '0) ? S_ACK : S_FL_SCAN;
			end
			S_FL_SCAN: begin
				if (scan_q[col_q]) begin
					store_req.pix_rd   = 1'b1;
					store_req.pix_addr = store_addr(y_q, col_q);
					state_d = S_FL_EMIT;
				end
			end
			S_FL_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					o_kind   = KIND_DATA;
					o_col    = CCOL_W'(col_q);
					o_row    = CROW_W'(y_q);
					o_left   = expand_pair(pix_rdata[1:0], pix_rdata[3:2]);
					o_right  = expand_pair(pix_rdata[5:4], pix_rdata[7:6]);
					o_last   = fl_last;
					if (fl_last) begin
						// every dirty byte of the row is out: clear its word
						store_req.dty_wr   = 1'b1;
						store_req.dty_addr = ROW_W'(y_q);
						state_d = S_IDLE;
					end else begin
						state_d = S_FL_SCAN;
					end
				end
			end
			S_ACK: begin
				if (slot_free) begin
					out_load = 1'b1;
					o_kind   = ack_kind_q;
					o_row    = (ack_kind_q == KIND_EMPTY) ? CROW_W'(y_q) : '0;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			clr_dirty_q <= 1'b1;
			clr_ack_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				cnt_q <= cnt_q + PIX_AW'(1);
			end
			if (accept && (cmd_ch.cmd == CMD_CLEAR)) begin
				cnt_q       <= '0;
				clr_dirty_q <= 1'b0;
				clr_ack_q   <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command latch and flush walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q        <= cmd_ch.x;
			y_q        <= cmd_ch.y;
			value_q    <= cmd_ch.value;
			ack_kind_q <= (cmd_ch.cmd == CMD_FLUSH) ? KIND_EMPTY : KIND_ACK;
		end
		if (state_q == S_FL_LOAD) begin
			scan_q <= dty_rdata;
			col_q  <= '0;
		end else if ((state_q == S_FL_SCAN) && !scan_q[col_q]) begin
			col_q <= col_q + COL_W'(1);
		end else if ((state_q == S_FL_EMIT) && out_load) begin
			scan_q <= scan_rest;
			col_q  <= col_q + COL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q    <= o_kind;
			out_col_q     <= o_col;
			out_row_q     <= o_row;
			out_left_q    <= o_left;
			out_right_q   <= o_right;
			out_changed_q <= o_changed;
			out_last_q    <= o_last;
		end
	end

	assign res_ch.valid        = out_valid_q;
	assign res_ch.kind         = out_kind_q;
	assign res_ch.cell_column  = out_col_q;
	assign res_ch.cell_row     = out_row_q;
	assign res_ch.pixels_left  = out_left_q;
	assign res_ch.pixels_right = out_right_q;
	assign res_ch.changed      = out_changed_q;
	assign res_ch.last         = out_last_q;

	// a store write from set pixel must come with a changed acknowledge
	`DTGF_ASSERT_NEXT(a_sp_write_acked, (state_q == S_SP_WR) && store_req.pix_wr, out_valid_q && out_changed_q, "set pixel write without changed ack")
	// a waiting result is never overwritten
	`DTGF_ASSERT_NEXT(a_out_held, out_valid_q && !res_ch.ready, out_valid_q && $stable(out_kind_q) && $stable(out_col_q) && $stable(out_last_q), "pending result overwritten")
	// the final emitted byte of a flush clears the row's dirty word
	`DTGF_ASSERT_SAME(a_flush_clears, (state_q == S_FL_EMIT) && out_load && fl_last, store_req.dty_wr && (store_req.dty_wdata == '0), "flush end left dirty word")

endmodule
